@@ rtl/core/lsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared codes for the latency statistics histogram.
// ----------------------------------------------------------------------------
package lsh_pkg;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

endpackage

@@ rtl/core/latency_stats_histogram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_stats_histogram
// Sample store with mean, maximum and histogram readout.
// ----------------------------------------------------------------------------
// A record word appends its sample while the store has room.
// A query reads the sample memory once for sum and maximum, divides the sum
// by the count on the shared divider (SW = 32 + $clog2(MAX_SAMPLES+1) bits,
// 43 by default) while the bin width max/NUM_BINS comes from a reciprocal
// multiply, clears the bin memory, reads each sample again and runs it
// through the divider for its bin, then sends NUM_BINS result words, each
// held while the result side stalls. The divider makes one quotient bit per
// cycle. One item is in work at a time and the input stalls until the last
// result word is taken. Bin counter updates run strictly one after another,
// so a read never overlaps a pending write to the same entry.
module latency_stats_histogram #(
   parameter int MAX_SAMPLES = 1024,
   parameter int NUM_BINS    = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_sample_ns,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_average_ns,
   output logic [31:0] rsp_max_ns,
   output logic [3:0]  rsp_bin_id,
   output logic [10:0] rsp_bin_count,
   output logic        rsp_last
);

   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int BW = $clog2(NUM_BINS);
   localparam int HW = CW;
   localparam int SW = 32 + CW;
   // floor(2^32 / NUM_BINS); the estimate it gives is at most one low
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(NUM_BINS));
   localparam logic [BW-1:0] TOP_BIN = BW'(NUM_BINS - 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SUM  = 4'd1;
   localparam logic [3:0] ST_AVG  = 4'd2;
   localparam logic [3:0] ST_AVGW = 4'd3;
   localparam logic [3:0] ST_CLR  = 4'd4;
   localparam logic [3:0] ST_RD   = 4'd5;
   localparam logic [3:0] ST_DLD  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_HWR  = 4'd8;
   localparam logic [3:0] ST_ORD  = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;
   localparam logic [3:0] ST_WAIT = 4'd11;

   logic [31:0]   mem [MAX_SAMPLES];
   logic [HW-1:0] hist [NUM_BINS];
   logic [31:0]   mem_q;
   logic [HW-1:0] hist_q;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic          hist_we;
   logic [BW-1:0] hist_wa, hist_ra;
   logic [HW-1:0] hist_wd;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rdp_ff, rdp_in;
   logic [BW-1:0] bin_ff, bin_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [31:0]   max_ff, max_in;
   logic [31:0]   avg_ff, avg_in;
   logic [31:0]   q0_ff, q0_in;
   logic [31:0]   width_ff, width_in;
   logic          rv_ff, rv_in;
   logic [HW-1:0] rc_ff, rc_in;
   logic          rl_ff, rl_in;
   logic [BW-1:0] ri_ff, ri_in;

   logic          div_start;
   logic [SW-1:0] div_dividend;
   logic [31:0]   div_divisor;
   logic          div_done;
   logic [SW-1:0] div_quot;
   logic [BW-1:0] bin_sel;
   logic [31:0]   q_est;
   logic [31:0]   rem_est;
   logic [31:0]   w_est;

   lsh_divider #(.DW(SW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quot)
   );

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= req_sample_ns;
      mem_q <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist[hist_wa] <= hist_wd;
      hist_q <= hist[hist_ra];
   end

   assign bin_sel = (div_quot >= SW'(NUM_BINS)) ? TOP_BIN : div_quot[BW-1:0];

   // width = max / NUM_BINS: reciprocal estimate, then one correction step
   assign q_est   = 32'(({32'd0, max_ff} * {32'd0, RECIP}) >> 32);
   assign rem_est = max_ff - 32'(q0_ff * 32'(NUM_BINS));
   assign w_est   = (rem_est >= 32'(NUM_BINS)) ? q0_ff + 32'd1 : q0_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      rdp_in   = rdp_ff;
      bin_in   = bin_ff;
      sum_in   = sum_ff;
      max_in   = max_ff;
      avg_in   = avg_ff;
      q0_in    = q0_ff;
      width_in = width_ff;
      rv_in    = rv_ff;
      rc_in    = rc_ff;
      rl_in    = rl_ff;
      ri_in    = ri_ff;
      mem_we   = 1'b0;
      mem_wa   = count_ff[AW-1:0];
      mem_ra   = idx_ff[AW-1:0];
      hist_we  = 1'b0;
      hist_wa  = bin_ff;
      hist_wd  = '0;
      hist_ra  = bin_ff;
      div_start    = 1'b0;
      div_dividend = sum_ff;
      div_divisor  = 32'(count_ff);
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == lsh_pkg::OP_RECORD) begin
                  if (count_ff < CW'(MAX_SAMPLES)) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  idx_in   = '0;
                  rdp_in   = 1'b0;
                  sum_in   = '0;
                  max_in   = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            // pipelined: address idx, consume previous read
            if (rdp_ff) begin
               sum_in = sum_ff + SW'(mem_q);
               if (mem_q > max_ff) max_in = mem_q;
            end
            if (idx_ff != count_ff) begin
               idx_in = idx_ff + CW'(1);
               rdp_in = 1'b1;
            end else begin
               rdp_in   = 1'b0;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            div_start = 1'b1;
            q0_in     = q_est;
            state_in  = ST_AVGW;
         end
         ST_AVGW: begin
            width_in = (w_est == 32'd0) ? 32'd1 : w_est;
            if (div_done) begin
               avg_in   = (count_ff == '0) ? 32'd0 : div_quot[31:0];
               bin_in   = '0;
               state_in = ST_CLR;
            end
         end
         ST_CLR: begin
            hist_we = 1'b1;
            if (bin_ff == TOP_BIN) begin
               idx_in   = '0;
               state_in = ST_RD;
            end else bin_in = bin_ff + BW'(1);
         end
         ST_RD: begin
            if (idx_ff == count_ff) begin
               bin_in   = '0;
               state_in = ST_ORD;
            end else state_in = ST_DLD;
         end
         ST_DLD: begin
            div_start    = 1'b1;
            div_dividend = SW'(mem_q);
            div_divisor  = width_ff;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               bin_in   = bin_sel;
               hist_ra  = bin_sel;
               state_in = ST_HWR;
            end
         end
         ST_HWR: begin
            hist_we  = 1'b1;
            hist_wd  = hist_q + HW'(1);
            idx_in   = idx_ff + CW'(1);
            state_in = ST_RD;
         end
         ST_ORD: state_in = ST_OUT;
         ST_OUT: begin
            rc_in    = hist_q;
            ri_in    = bin_ff;
            rl_in    = (bin_ff == TOP_BIN);
            rv_in    = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rsp_stall) begin
               rv_in = 1'b0;
               if (rl_ff) state_in = ST_IDLE;
               else begin
                  bin_in   = bin_ff + BW'(1);
                  state_in = ST_ORD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      idx_ff   <= idx_in;
      rdp_ff   <= rdp_in;
      bin_ff   <= bin_in;
      sum_ff   <= sum_in;
      max_ff   <= max_in;
      avg_ff   <= avg_in;
      q0_ff    <= q0_in;
      width_ff <= width_in;
      rc_ff    <= rc_in;
      rl_ff    <= rl_in;
      ri_ff    <= ri_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_average_ns = avg_ff;
   assign rsp_max_ns     = max_ff;
   assign rsp_bin_id     = 4'(ri_ff);
   assign rsp_bin_count  = 11'(rc_ff);
   assign rsp_last       = rl_ff;

endmodule

@@ rtl/core/lsh_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_divider
// Restoring radix-2 divider, DW-bit unsigned dividend by a 32-bit divisor,
// one quotient bit per cycle; done pulses once the last quotient bit is registered.
// ----------------------------------------------------------------------------
module lsh_divider #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [31:0]   divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int NW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic [32:0]   shifted;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = 32'd0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + NW'(1);
         if (cnt_ff == NW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/lsh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_checker
// Port-level checks for the latency statistics histogram.
// ----------------------------------------------------------------------------
module lsh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_average_ns,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average_ns))
      else $error("result word changed while stalled");

   a_no_accept_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken during query readout");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind latency_stats_histogram lsh_checker u_lsh_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_average_ns(rsp_average_ns), .rsp_last(rsp_last)
);
